### hw/rtl/rect_collider_table_assert.svh
// Assertion macros for the rectangle collider table.
`ifndef RECT_COLLIDER_TABLE_ASSERT_SVH
`define RECT_COLLIDER_TABLE_ASSERT_SVH
`ifndef SYNTH
// Check a property at every clock edge outside reset.
`define RCT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rct: assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define RCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rct: implication failed");
// Check that a condition implies a consequence in the next cycle.
`define RCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rct: next-cycle implication failed");
`else
`define RCT_ASSERT(label, clk, rst_n, prop)
`define RCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/rct_pkg.sv
// Shared types, codes and constants of the rectangle collider table.
`timescale 1ns / 1ps
package rct_pkg;

  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned IdW    = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned ActW   = 2;
  localparam int unsigned StatW  = 2;

  typedef enum logic [ActW-1:0] {
    ActAdd    = 2'd0,
    ActRemove = 2'd1,
    ActQuery  = 2'd2,
    ActMove   = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    StatDone     = 2'd0,
    StatNotFound = 2'd1,
    StatFull     = 2'd2
  } status_e;

  // One stored rectangle: id, left, top, width, height.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [SizeW-1:0]  w;
    logic [SizeW-1:0]  h;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic do_add;
    logic scan_step;
    logic rd_last;
    logic wr_last;
    logic wr_move;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    found;
    logic    scan_done;
  } sts_t;

endpackage

### hw/rtl/rect_collider_table.sv
// Top level of the rectangle collider table.
`timescale 1ns / 1ps
// Table of up to MaxEntries boxes tagged with 8-bit ids; starts empty,
// no clearing pass. Each request gives one response. Remove, move and query
// scan the table through the single read port of the entry memory, one entry
// per cycle; a remove then copies the last entry into the matched slot, and a
// move rewrites the matched slot. A new request is taken while the last
// response still waits; the response stage then holds until the output
// register is free.
module rect_collider_table #(
  parameter int unsigned MaxEntries = rct_pkg::MaxEntriesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rct_pkg::ActW-1:0]          action_i,
  input  logic [rct_pkg::IdW-1:0]           object_id_i,
  input  logic signed [rct_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [rct_pkg::CoordW-1:0] pos_y_i,
  input  logic [rct_pkg::SizeW-1:0]         box_width_i,
  input  logic [rct_pkg::SizeW-1:0]         box_height_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rct_pkg::StatW-1:0]         status_o,
  output logic                              hit_o,
  output logic [rct_pkg::IdW-1:0]           hit_id_o
);

  rct_pkg::cmd_t cmd;
  rct_pkg::sts_t sts;

  rct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rct_datapath #(
    .MaxEntries(MaxEntries)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .object_id_i (object_id_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .box_width_i (box_width_i),
    .box_height_i(box_height_i),
    .status_o    (status_o),
    .hit_o       (hit_o),
    .hit_id_o    (hit_id_o)
  );

endmodule

### hw/rtl/rct_datapath.sv
// Datapath of the rectangle collider table: entry memory, count, scan and result.
`timescale 1ns / 1ps
`include "rect_collider_table_assert.svh"
module rct_datapath #(
  parameter int unsigned MaxEntries = rct_pkg::MaxEntriesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rct_pkg::cmd_t                     cmd_i,
  output rct_pkg::sts_t                     sts_o,
  input  logic [rct_pkg::ActW-1:0]          action_i,
  input  logic [rct_pkg::IdW-1:0]           object_id_i,
  input  logic signed [rct_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [rct_pkg::CoordW-1:0] pos_y_i,
  input  logic [rct_pkg::SizeW-1:0]         box_width_i,
  input  logic [rct_pkg::SizeW-1:0]         box_height_i,
  output logic [rct_pkg::StatW-1:0]         status_o,
  output logic                              hit_o,
  output logic [rct_pkg::IdW-1:0]           hit_id_o
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxEntries);
  localparam int unsigned SumW = rct_pkg::CoordW + 2;

  // Strict overlap of two boxes in exact signed arithmetic.
  function automatic logic overlap(rct_pkg::entry_t a, rct_pkg::entry_t b);
    logic signed [SumW-1:0] ax, ay, bx, by, ax2, ay2, bx2, by2;
    ax  = {{2{a.x[rct_pkg::CoordW-1]}}, a.x};
    ay  = {{2{a.y[rct_pkg::CoordW-1]}}, a.y};
    bx  = {{2{b.x[rct_pkg::CoordW-1]}}, b.x};
    by  = {{2{b.y[rct_pkg::CoordW-1]}}, b.y};
    ax2 = ax + {3'b000, a.w};
    ay2 = ay + {3'b000, a.h};
    bx2 = bx + {3'b000, b.w};
    by2 = by + {3'b000, b.h};
    return (ax < bx2) && (ax2 > bx) && (ay < by2) && (ay2 > by);
  endfunction

  rct_pkg::entry_t  mem_q [MaxEntries];
  rct_pkg::entry_t  req_q, rd_q, wd;
  rct_pkg::action_e act_q;
  rct_pkg::status_e res_status_q, out_status_q;
  logic             res_hit_q, out_hit_q;
  logic [rct_pkg::IdW-1:0] res_hit_id_q, out_hit_id_q;
  logic [CntW-1:0]  count_q, scan_q, last_cnt;
  logic             pend_q;
  logic [IdxW-1:0]  pend_idx_q, slot_q, rd_addr, wa;
  logic             full, scan_more, id_match, found, scan_done, we;

  assign full      = (count_q == CntMax);
  assign last_cnt  = count_q - CntW'(1);
  assign scan_more = (scan_q < count_q);
  assign rd_addr   = cmd_i.rd_last ? last_cnt[IdxW-1:0] : scan_q[IdxW-1:0];
  assign id_match  = (rd_q.id == req_q.id);
  assign found     = pend_q && ((act_q == rct_pkg::ActQuery) ?
                                (!id_match && overlap(req_q, rd_q)) : id_match);
  assign scan_done = !pend_q && !scan_more;

  assign sts_o.action    = act_q;
  assign sts_o.found     = found;
  assign sts_o.scan_done = scan_done;

  // Select the memory write: append, copy of the last entry, or moved box.
  always_comb begin
    we = 1'b0;
    wa = slot_q;
    wd = req_q;
    priority if (cmd_i.do_add && !full) begin
      we = 1'b1;
      wa = count_q[IdxW-1:0];
    end else if (cmd_i.wr_last) begin
      we = 1'b1;
      wd = rd_q;
    end else if (cmd_i.wr_move) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Track the fill count and advance the scan pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        scan_q <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        pend_q <= scan_more;
        if (scan_more) begin
          scan_q <= scan_q + CntW'(1);
        end
      end
      if (cmd_i.do_add && !full) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.wr_last) begin
        count_q <= last_cnt;
      end
    end
  end

  // Hold the request, build the result and load the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q        <= {object_id_i, pos_x_i, pos_y_i, box_width_i, box_height_i};
      act_q        <= rct_pkg::action_e'(action_i);
      res_status_q <= rct_pkg::StatDone;
      res_hit_q    <= 1'b0;
      res_hit_id_q <= '0;
    end
    if (cmd_i.do_add && full) begin
      res_status_q <= rct_pkg::StatFull;
    end
    if (cmd_i.scan_step) begin
      pend_idx_q <= scan_q[IdxW-1:0];
      if (found) begin
        slot_q <= pend_idx_q;
        if (act_q == rct_pkg::ActQuery) begin
          res_hit_q    <= 1'b1;
          res_hit_id_q <= rd_q.id;
        end
      end else if (scan_done && act_q != rct_pkg::ActQuery) begin
        res_status_q <= rct_pkg::StatNotFound;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
      out_hit_id_q <= res_hit_id_q;
    end
  end

  assign status_o = out_status_q;
  assign hit_o    = out_hit_q;
  assign hit_id_o = out_hit_id_q;

  `RCT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntMax)
  `RCT_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, cmd_i.do_add && full, count_q == CntMax)
  `RCT_ASSERT_NEXT(a_remove_shrinks, clk_i, rst_ni, cmd_i.wr_last, count_q == $past(last_cnt))
  `RCT_ASSERT_IMP(a_found_nonempty, clk_i, rst_ni, cmd_i.scan_step && found, count_q != '0)

endmodule

### hw/rtl/rct_ctrl.sv
// Controller of the rectangle collider table: sequences add, scan, copy, move and response.
`timescale 1ns / 1ps
module rct_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [rct_pkg::ActW-1:0] action_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  rct_pkg::sts_t            sts_i,
  output rct_pkg::cmd_t            cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StAdd    = 7'b0000010,
    StScan   = 7'b0000100,
    StLastRd = 7'b0001000,
    StLastWr = 7'b0010000,
    StMoveWr = 7'b0100000,
    StResp   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = (rct_pkg::action_e'(action_i) == rct_pkg::ActAdd) ? StAdd : StScan;
        end
      end
      StAdd: begin
        cmd_o.do_add = 1'b1;
        state_d = StResp;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.found) begin
          unique case (sts_i.action)
            rct_pkg::ActRemove: state_d = StLastRd;
            rct_pkg::ActMove:   state_d = StMoveWr;
            default:            state_d = StResp;
          endcase
        end else if (sts_i.scan_done) begin
          state_d = StResp;
        end
      end
      StLastRd: begin
        cmd_o.rd_last = 1'b1;
        state_d = StLastWr;
      end
      StLastWr: begin
        cmd_o.wr_last = 1'b1;
        state_d = StResp;
      end
      StMoveWr: begin
        cmd_o.wr_move = 1'b1;
        state_d = StResp;
      end
      StResp: begin
        // Hand over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
